### rtl/time_weighted_average_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the time weighted average block
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIME_WEIGHTED_AVERAGE_TOP_ASSERT_SVH
`define TIME_WEIGHTED_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication.
`define TWA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TWA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/twa_pkg.sv
// ----------------------------------------------------------------------------
// twa_pkg
// Types and fixed constants of the time weighted average block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twa_pkg;

    // Accumulator and quotient widths are fixed at 64 bits.
    localparam int SUM_BITS     = 64;
    localparam int HALF_BITS    = SUM_BITS / 2;
    localparam int PROD_BITS    = 2 * SUM_BITS;
    localparam int AVG_BITS     = 31;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

    // Four 32x32 partial products per multiply.
    localparam logic [1:0] MUL_LAST_STEP = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_MUL,
        ST_SUM,
        ST_COMMIT,
        ST_DIV,
        ST_RESULT
    } twa_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } twa_div_stat_t;

endpackage

`default_nettype wire

### rtl/twa_div.sv
// ----------------------------------------------------------------------------
// twa_div
// Restoring divider, one quotient bit per cycle, for a 64-bit quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twa_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [twa_pkg::SUM_BITS-1:0]  dividend,
    input  wire logic [twa_pkg::SUM_BITS-1:0]  divisor,
    output      logic [twa_pkg::SUM_BITS-1:0]  quotient,
    output      twa_pkg::twa_div_stat_t        stat
);
    import twa_pkg::*;

    logic [SUM_BITS-1:0]     rem_reg;
    logic [SUM_BITS-1:0]     rem_next;
    logic [SUM_BITS-1:0]     quo_reg;
    logic [SUM_BITS-1:0]     quo_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [SUM_BITS:0]       shifted;
    logic [SUM_BITS+1:0]     diff;
    logic                    fits;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[SUM_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};
    assign fits    = ~diff[SUM_BITS+1];

    always_comb
    begin
        rem_next = fits ? diff[SUM_BITS-1:0] : shifted[SUM_BITS-1:0];
        quo_next = {quo_reg[SUM_BITS-2:0], fits};
    end

    // Advance one bit per cycle while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(SUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load operands on start, shift while busy
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

### rtl/time_weighted_average_top.sv
// ----------------------------------------------------------------------------
// time_weighted_average_top
// Time weighted average of a sampled count over a window of samples.
//
// Input channel (in_valid / in_stall): one item per sample, carrying
// sample_time, sample_count and is_last. The block takes an item only when
// idle; in_stall is high for the whole time an item is being worked on.
// An item that opens a window goes from idle straight to commit; each
// later item runs gap subtract, four 32x32 partial products on one shared
// multiplier, saturating sum update and commit, or only gap subtract and
// commit when its timestamp is earlier than the previous one and the pair
// is skipped. An item with is_last set also runs the serial divider and
// then loads the output register before the block is idle again. Output
// channel (out_valid / out_stall): one item per window with average and
// sum_saturated. While the receiver stalls, the result holds and the block
// keeps taking new samples; a second window close waits until the output
// register is free.
// Reset clears all window state and drops out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "time_weighted_average_top_assert.svh"

module time_weighted_average_top #(
    parameter int COUNT_BITS = 32,
    parameter int TIME_BITS  = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [TIME_BITS-1:0]              sample_time,
    input  wire logic signed [COUNT_BITS-1:0]      sample_count,
    input  wire logic                              is_last,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [twa_pkg::AVG_BITS-1:0]      average,
    output      logic                              sum_saturated
);
    import twa_pkg::*;

    localparam int MAG_BITS = COUNT_BITS - 1;

    twa_state_t state_reg;
    twa_state_t state_next;

    // Current item
    logic [TIME_BITS-1:0]  now_reg;
    logic [MAG_BITS-1:0]   cnt_reg;
    logic                  last_reg;

    // Window state
    logic [TIME_BITS-1:0]  prev_time_reg;
    logic [MAG_BITS-1:0]   prev_count_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [SUM_BITS-1:0]   sum_next;
    logic [SUM_BITS-1:0]   elapsed_reg;
    logic [SUM_BITS-1:0]   elapsed_next;
    logic                  have_prev_reg;
    logic                  ovf_reg;

    // Multiply datapath
    logic [TIME_BITS-1:0]  gap_reg;
    logic [1:0]            step_reg;
    logic [PROD_BITS-1:0]  acc_reg;
    logic [PROD_BITS-1:0]  acc_next;

    // Output register
    logic                  out_valid_reg;
    logic [AVG_BITS-1:0]   average_reg;
    logic                  sum_saturated_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  div_start;
    logic                  load_out;
    logic [MAG_BITS-1:0]   clamped;
    logic [TIME_BITS:0]    gap_diff;
    logic                  time_back;
    logic [SUM_BITS-1:0]   gap_ext;
    logic [SUM_BITS-1:0]   cnt_ext;
    logic [HALF_BITS-1:0]  mul_a;
    logic [HALF_BITS-1:0]  mul_b;
    logic [SUM_BITS-1:0]   pp;
    logic [PROD_BITS-1:0]  pp_ext;
    logic [PROD_BITS-1:0]  pp_shifted;
    logic [1:0]            pp_pos;
    logic [SUM_BITS:0]     sum_add;
    logic                  sum_ovf;
    logic [SUM_BITS:0]     elapsed_add;
    logic                  elapsed_ovf;
    logic [SUM_BITS-1:0]   quotient;
    logic [AVG_BITS-1:0]   avg_value;
    twa_div_stat_t         div_stat;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Drop negative counts to zero
    assign clamped = sample_count[COUNT_BITS-1] ? '0 : sample_count[MAG_BITS-1:0];

    // Gap and backward-time detect share one subtract
    assign gap_diff  = {1'b0, now_reg} - {1'b0, prev_time_reg};
    assign time_back = gap_diff[TIME_BITS];

    // Shared 32x32 multiplier, one partial product per step
    assign gap_ext = SUM_BITS'(gap_reg);
    assign cnt_ext = SUM_BITS'(prev_count_reg);
    assign mul_a   = step_reg[0] ? gap_ext[SUM_BITS-1:HALF_BITS] : gap_ext[HALF_BITS-1:0];
    assign mul_b   = step_reg[1] ? cnt_ext[SUM_BITS-1:HALF_BITS] : cnt_ext[HALF_BITS-1:0];
    assign pp      = SUM_BITS'(mul_a) * SUM_BITS'(mul_b);
    assign pp_ext  = PROD_BITS'(pp);
    assign pp_pos  = {1'b0, step_reg[0]} + {1'b0, step_reg[1]};

    always_comb
    begin
        case (pp_pos)
            2'd0:    pp_shifted = pp_ext;
            2'd1:    pp_shifted = pp_ext << HALF_BITS;
            default: pp_shifted = pp_ext << SUM_BITS;
        endcase
        acc_next = acc_reg + pp_shifted;
    end

    // Saturating elapsed-time add
    assign elapsed_add  = {1'b0, elapsed_reg} + {1'b0, gap_ext};
    assign elapsed_ovf  = elapsed_add[SUM_BITS];
    assign elapsed_next = elapsed_ovf ? '1 : elapsed_add[SUM_BITS-1:0];

    // Saturating weighted-sum add
    assign sum_add  = {1'b0, sum_reg} + {1'b0, acc_reg[SUM_BITS-1:0]};
    assign sum_ovf  = (acc_reg[PROD_BITS-1:SUM_BITS] != '0) || sum_add[SUM_BITS];
    assign sum_next = sum_ovf ? '1 : sum_add[SUM_BITS-1:0];

    // Clamp the quotient to the 31-bit result range
    always_comb
    begin
        if (elapsed_reg == '0)
            avg_value = '0;
        else if (quotient[SUM_BITS-1:AVG_BITS] != '0)
            avg_value = '1;
        else
            avg_value = quotient[AVG_BITS-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = have_prev_reg ? ST_GAP : ST_COMMIT;
            end
            ST_GAP:
            begin
                state_next = time_back ? ST_COMMIT : ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg == MUL_LAST_STEP)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = last_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:   in_stall  = 1'b0;
            ST_COMMIT: div_start = last_reg;
            ST_RESULT: load_out  = out_free;
            default:   in_stall  = 1'b1;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg  <= sample_time;
            cnt_reg  <= clamped;
            last_reg <= is_last;
        end
    end

    // Gap, step counter and product accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (state_reg == ST_GAP)
        begin
            step_reg <= '0;
        end
        else if (state_reg == ST_MUL)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GAP)
        begin
            gap_reg <= gap_diff[TIME_BITS-1:0];
            acc_reg <= '0;
        end
        else if (state_reg == ST_MUL)
        begin
            acc_reg <= acc_next;
        end
    end

    // Window state: accumulate, commit, clear after the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg  <= '0;
            prev_count_reg <= '0;
            sum_reg        <= '0;
            elapsed_reg    <= '0;
            have_prev_reg  <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_MUL && step_reg == 2'd0)
            begin
                elapsed_reg <= elapsed_next;
                if (elapsed_ovf)
                    ovf_reg <= 1'b1;
            end
            if (state_reg == ST_SUM)
            begin
                sum_reg <= sum_next;
                if (sum_ovf)
                    ovf_reg <= 1'b1;
            end
            if (state_reg == ST_COMMIT)
            begin
                prev_time_reg  <= now_reg;
                prev_count_reg <= cnt_reg;
                have_prev_reg  <= 1'b1;
            end
            if (load_out)
            begin
                prev_time_reg  <= '0;
                prev_count_reg <= '0;
                sum_reg        <= '0;
                elapsed_reg    <= '0;
                have_prev_reg  <= 1'b0;
                ovf_reg        <= 1'b0;
            end
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            average_reg       <= avg_value;
            sum_saturated_reg <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average       = average_reg;
    assign sum_saturated = sum_saturated_reg;

    // Serial divider for the window close
    twa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (elapsed_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Checks
    `TWA_ASSERT_NOW(a_no_accept_while_dividing, in_accept, !div_stat.busy,
        "input item accepted while the divider is busy")
    `TWA_ASSERT_NOW(a_out_rise_from_result, $rose(out_valid), $past(state_reg == ST_RESULT),
        "out_valid rose without a result load")
    `TWA_ASSERT_NEXT(a_clear_after_load, load_out,
        !have_prev_reg && sum_reg == '0 && elapsed_reg == '0 && !ovf_reg,
        "window state not cleared after result load")

endmodule

`default_nettype wire

### bench/tb_time_weighted_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_time_weighted_average_top
// Drives windows of timestamped count samples into the time weighted average
// block; checks each window result against a cycle-free bench model, or
// marked table rows against the table. A short table covers corner cases
// first, then random windows under three input and output idle patterns.
// ----------------------------------------------------------------------------

module tb_time_weighted_average_top;

    import twa_pkg::*;

    localparam int CNT_W     = 32;
    localparam int TIME_W    = 64;
    localparam int N_ITEMS   = 1350;
    localparam int N_DIR     = 21;
    localparam logic [63:0]         ONES64  = '1;
    localparam logic [AVG_BITS-1:0] AVG_TOP = '1;

    typedef struct packed {
        logic [AVG_BITS-1:0] avg;
        logic                sat;
    } window_result_t;

    typedef struct packed {
        logic [TIME_W-1:0]   t;
        logic [CNT_W-1:0]    c;
        logic                last;
        logic                typed;
        logic [AVG_BITS-1:0] avg;
        logic                sat;
    } dir_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [TIME_W-1:0]        sample_time = '0;
    logic signed [CNT_W-1:0]  sample_count = '0;
    logic                     is_last = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [AVG_BITS-1:0]      average;
    logic                     sum_saturated;

    // Window model state
    logic [63:0] last_time;
    logic [63:0] last_count;
    logic [63:0] weight_sum;
    logic [63:0] time_total;
    logic        seen_sample;
    logic        sat_seen;

    window_result_t window_results [$];
    dir_row_t       dir_rows [0:N_DIR-1];
    int             n_errors = 0;
    int             n_sent = 0;
    int             send_idle_pct = 29;
    int             recv_idle_pct = 86;

    time_weighted_average_top #(
        .COUNT_BITS (CNT_W),
        .TIME_BITS  (TIME_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_time   (sample_time),
        .sample_count  (sample_count),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average       (average),
        .sum_saturated (sum_saturated)
    );

    always #10 clk = ~clk;

    // Clear the window model
    task automatic clear_window();
        last_time   = '0;
        last_count  = '0;
        weight_sum  = '0;
        time_total  = '0;
        seen_sample = 1'b0;
        sat_seen    = 1'b0;
    endtask

    // Fold one sample into the window; report the average on the closing one
    task automatic fold_sample(input logic [TIME_W-1:0] t, input logic [CNT_W-1:0] c,
                               input logic last, output logic done,
                               output window_result_t res);
        logic [63:0] gap;
        logic [63:0] quot;
        done = 1'b0;
        res  = '0;
        if (seen_sample && t >= last_time) begin
            gap = t - last_time;
            if (last_count != 0 && gap != 0) begin
                if (gap > (ONES64 - weight_sum) / last_count) begin
                    weight_sum = ONES64;
                    sat_seen   = 1'b1;
                end
                else
                    weight_sum = weight_sum + gap * last_count;
            end
            if (gap > ONES64 - time_total) begin
                time_total = ONES64;
                sat_seen   = 1'b1;
            end
            else
                time_total = time_total + gap;
        end
        last_time   = t;
        last_count  = c[CNT_W-1] ? 64'd0 : {{(64-CNT_W){1'b0}}, c};
        seen_sample = 1'b1;
        if (last) begin
            quot = (time_total != 0) ? weight_sum / time_total : 64'd0;
            if (quot > {33'd0, AVG_TOP})
                quot = {33'd0, AVG_TOP};
            res.avg = quot[AVG_BITS-1:0];
            res.sat = sat_seen;
            done    = 1'b1;
            clear_window();
        end
    endtask

    // Present one item, hold it until taken, then queue what it should produce
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic [CNT_W-1:0] c,
                               input logic last, input logic typed,
                               input window_result_t typed_res);
        logic           done;
        window_result_t res;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        sample_time  <= t;
        sample_count <= c;
        is_last      <= last;
        do
            @(posedge clk);
        while (in_stall);
        fold_sample(t, c, last, done, res);
        if (done)
            window_results.push_back(typed ? typed_res : res);
        n_sent++;
        // Switch the idle pattern as the run moves on
        if (n_sent == N_ITEMS / 3) begin
            send_idle_pct = 86;
            recv_idle_pct = 29;
        end
        else if (n_sent == 2 * N_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // Pick the next timestamp of a window
    function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] prev);
        int mode;
        mode = $urandom_range(0, 15);
        case (mode)
            0:       return {$urandom, $urandom};
            1:       return prev - $urandom_range(1, 500);
            2:       return prev;
            3:       return prev + {$urandom, $urandom} >> $urandom_range(0, 40);
            4:       return ONES64 - $urandom_range(0, 3);
            default: return prev + $urandom_range(1, 1000);
        endcase
    endfunction

    // Pick a sample count
    function automatic logic [CNT_W-1:0] pick_count();
        int mode;
        mode = $urandom_range(0, 15);
        case (mode)
            0, 1:    return -$urandom_range(1, 100000);
            2, 3:    return $urandom;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'h8000_0000;
            6:       return '0;
            default: return $urandom_range(0, 5000);
        endcase
    endfunction

    // Compare each taken result with the oldest expectation
    always @(posedge clk) begin
        window_result_t exp_res;
        if (rst_n && out_valid && !out_stall) begin
            if (window_results.size() == 0) begin
                $error("unexpected result: average %0d sum_saturated %0d",
                       average, sum_saturated);
                n_errors++;
            end
            else begin
                exp_res = window_results.pop_front();
                if (average !== exp_res.avg) begin
                    $error("average: expected %0d, actual %0d", exp_res.avg, average);
                    n_errors++;
                end
                if (sum_saturated !== exp_res.sat) begin
                    $error("sum_saturated: expected %0d, actual %0d",
                           exp_res.sat, sum_saturated);
                    n_errors++;
                end
            end
        end
    end

    // Stall the output side at random
    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Stimulus: directed table, then random windows, then drain
    initial begin
        window_result_t     typed_res;
        logic [TIME_W-1:0]  t;
        int                 win_len;
        dir_rows = '{
            // single sample window
            '{64'd0, 32'd0, 1'b1, 1'b1, 31'd0, 1'b0},
            // plain two-sample window
            '{64'd100, 32'd5, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'd200, -32'sd3, 1'b1, 1'b1, 31'd5, 1'b0},
            // most negative count clamps to zero
            '{64'd0, 32'h8000_0000, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'd10, 32'd7, 1'b1, 1'b1, 31'd0, 1'b0},
            // largest count over one ns
            '{64'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'd1, 32'd0, 1'b1, 1'b1, 31'h7FFF_FFFF, 1'b0},
            // time going backward skips the pair
            '{64'd1000, 32'd50, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'd500, 32'd9, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'd600, 32'd1, 1'b1, 1'b0, 31'd0, 1'b0},
            // weighted sum saturates
            '{64'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 31'd0, 1'b0},
            '{ONES64, 32'd0, 1'b1, 1'b1, 31'd1, 1'b1},
            // elapsed total saturates
            '{64'd0, 32'd0, 1'b0, 1'b0, 31'd0, 1'b0},
            '{ONES64, 32'd0, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'd0, 32'd0, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'd5, 32'd0, 1'b1, 1'b1, 31'd0, 1'b1},
            // zero gap between samples
            '{64'd7, 32'd3, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'd7, 32'd4, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'd17, 32'hFFFF_FFFF, 1'b1, 1'b0, 31'd0, 1'b0},
            // alternating bit patterns, second sample is earlier
            '{64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 31'd0, 1'b0},
            '{64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1, 31'd0, 1'b0}
        };
        clear_window();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        for (int i = 0; i < N_DIR; i++) begin
            typed_res.avg = dir_rows[i].avg;
            typed_res.sat = dir_rows[i].sat;
            send_sample(dir_rows[i].t, dir_rows[i].c, dir_rows[i].last,
                        dir_rows[i].typed, typed_res);
        end

        // Random windows, mostly short, some long
        typed_res = '0;
        while (n_sent < N_ITEMS) begin
            win_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                   : $urandom_range(1, 8);
            t = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 100000));
            for (int k = 0; k < win_len; k++) begin
                send_sample(t, pick_count(), k == win_len - 1, 1'b0, typed_res);
                t = next_time(t);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then give the block time for anything stray
        while (window_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (n_errors == 0)
            $display("time_weighted_average_top: match");
        else
            $display("time_weighted_average_top: mismatch");
        $finish;
    end

    // Hard stop on a hang
    initial begin
        #30_000_000;
        $display("time_weighted_average_top: mismatch");
        $finish;
    end

endmodule
